>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the LRU key-value cache and its cells.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CFG_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
    } t_rsp;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  value;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic                     en;   // word accepted this cycle
        logic                     ins;  // put of a key not present
        logic signed [KEY_W-1:0]  key;
    } t_cell_ctl;

endpackage

>>> rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One entry of the recency-ordered row. Position in the row is the recency
// rank: a cell that shifts takes the entry of its more recent neighbor.
// ----------------------------------------------------------------------------
module lkv_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lkv_pkg::t_cell_ctl i_ctl,
    input  logic               i_in_range,  // inside the shift span on insert
    input  logic               i_carry,     // a less recent cell matched
    input  lkv_pkg::t_entry    i_prev,      // neighbor entry (new entry at head)
    output lkv_pkg::t_entry    o_entry,
    output logic               o_hit,
    output logic               o_carry
);

    lkv_pkg::t_entry r_entry;
    logic            w_shift;

    assign o_hit   = r_entry.valid && (r_entry.key == i_ctl.key);
    assign o_carry = o_hit || i_carry;
    assign o_entry = r_entry;

    // promote shifts the hit cell and everything more recent than it
    assign w_shift = i_ctl.en && (i_ctl.ins ? i_in_range : o_carry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_shift) begin
            r_entry.valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_entry.key   <= i_prev.key;
            r_entry.value <= i_prev.value;
        end
    end

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value store with LRU replacement, built as a row of
// cells ordered from most recent (cell 0) to least recent.
// ----------------------------------------------------------------------------
// Result: a get's result word is registered and valid in the cycle after the request is taken.
// Throughput: one request word per cycle while o_stall is low; the parallel key
//   compare and the one-step shift along the cell row complete as the word is taken.
// Reset: clears all valid marks, the entry count and the output valid flag;
//   capacity returns to 16. No clearing pass, ready right after reset.
module lru_key_value_cache_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  lkv_pkg::t_req                    i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output lkv_pkg::t_rsp                    o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lkv_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [lkv_pkg::CFG_W-1:0]   r_capacity;
    logic [lkv_pkg::CNT_W-1:0]   r_count;
    logic [lkv_pkg::CNT_W-1:0]   n_count;
    logic                        r_out_valid;
    lkv_pkg::t_rsp               r_out;

    logic [lkv_pkg::CNT_W-1:0]   w_cap;
    logic [lkv_pkg::CNT_W-1:0]   w_limit;
    logic                        w_accept;
    logic                        w_evict;
    logic                        w_any_hit;
    logic signed [lkv_pkg::VAL_W-1:0] w_hit_value;
    lkv_pkg::t_cell_ctl          w_ctl;
    lkv_pkg::t_entry             w_head;
    lkv_pkg::t_entry             w_entry [lkv_pkg::DEPTH];
    logic [lkv_pkg::DEPTH-1:0]   w_hit;
    logic [lkv_pkg::DEPTH:0]     w_carry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign w_accept    = i_valid && !o_stall;

    always_comb begin
        if (r_capacity == '0) begin
            w_cap = lkv_pkg::CNT_W'(1);
        end else if (int'(r_capacity) > lkv_pkg::DEPTH) begin
            w_cap = lkv_pkg::CNT_W'(lkv_pkg::DEPTH);
        end else begin
            w_cap = lkv_pkg::CNT_W'(r_capacity);
        end
    end

    // full store: the new entry drops the least recent one, at r_count-1
    assign w_evict = (r_count >= w_cap);
    assign w_limit = w_evict ? (r_count - lkv_pkg::CNT_W'(1)) : r_count;

    assign w_any_hit = w_carry[0];
    assign w_carry[lkv_pkg::DEPTH] = 1'b0;

    assign w_ctl.en  = w_accept;
    assign w_ctl.ins = (i_data.op == lkv_pkg::OP_PUT) && !w_any_hit;
    assign w_ctl.key = i_data.key;

    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            if (w_hit[i]) begin
                w_hit_value = w_hit_value | w_entry[i].value;
            end
        end
    end

    assign w_head.valid = 1'b1;
    assign w_head.key   = i_data.key;
    assign w_head.value = (i_data.op == lkv_pkg::OP_PUT) ? i_data.value : w_hit_value;

    for (genvar g = 0; g < lkv_pkg::DEPTH; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_in_range (lkv_pkg::CNT_W'(g) <= w_limit),
            .i_carry    (w_carry[g+1]),
            .i_prev     ((g == 0) ? w_head : w_entry[(g == 0) ? 0 : g-1]),
            .o_entry    (w_entry[g]),
            .o_hit      (w_hit[g]),
            .o_carry    (w_carry[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_accept && w_ctl.ins && !w_evict) begin
            n_count = r_count + lkv_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lkv_pkg::CFG_W'(16);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_accept && (i_data.op == lkv_pkg::OP_GET)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_data.op == lkv_pkg::OP_GET)) begin
            r_out.hit        <= w_any_hit;
            r_out.read_value <= w_hit_value;
        end
    end

endmodule

>>> rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_stall,
    input  lkv_pkg::t_req i_data,
    input  logic          o_valid,
    input  logic          i_stall,
    input  lkv_pkg::t_rsp o_data
);

    logic w_accept;
    assign w_accept = i_valid && !o_stall;

    // a result word waiting on the consumer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // the request side only backs up when the result register is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled with result register free");

    // every taken get gives one word, a taken put gives none
    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_valid == ($past(i_data.op) == lkv_pkg::OP_GET)))
        else $error("result word count does not follow request op");

    // a miss reports zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.read_value == '0)
        else $error("miss with nonzero value");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache_unit. A directed table covers
// reset misses, extreme keys and values, updates, eviction and the capacity
// corner cases (zero, saturated, lowered below the fill). It is followed by
// random get/put traffic over small key pools at several capacities. A
// behavioral LRU model predicts each get's response word where the table
// gives none. Both sides stall at random outside one calm phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 50;
    localparam int N_PHASES    = 8;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    lkv_pkg::t_req                 i_data      = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    lkv_pkg::t_rsp                 o_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [lkv_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    lru_key_value_cache_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // one line of the directed plan: either a capacity write or a request word
    typedef struct {
        bit                        is_cfg;
        logic [lkv_pkg::CFG_W-1:0] cfg_val;
        lkv_pkg::t_req             req;
        bit                        typed;
        lkv_pkg::t_rsp             want;
    } t_row;

    // shadow copy of the cache
    logic [lkv_pkg::KEY_W-1:0] shadow_key  [lkv_pkg::DEPTH];
    logic [lkv_pkg::VAL_W-1:0] shadow_val  [lkv_pkg::DEPTH];
    bit                        shadow_used [lkv_pkg::DEPTH];
    int unsigned               shadow_age  [lkv_pkg::DEPTH];
    int unsigned               shadow_fill = 0;
    logic [lkv_pkg::CFG_W-1:0] shadow_cap  = 5'd16;

    lkv_pkg::t_rsp    pending_reads [$];
    bit               cur_typed = 1'b0;
    lkv_pkg::t_rsp    cur_want  = '0;
    bit               calm      = 1'b0;

    int n_errors = 0;
    int n_gets   = 0;
    int n_puts   = 0;
    int n_hits   = 0;
    int n_cfg    = 0;
    int idle_cycles = 0;
    int phase_cap [0:N_PHASES-1] = '{16, 1, 4, 0, 31, 2, 17, 9};

    initial begin
        for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            shadow_used[i] = 1'b0;
            shadow_age[i]  = 0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // entries more recent than slot age by one, slot becomes the newest
    function automatic void make_recent(int slot);
        for (int i = 0; i < lkv_pkg::DEPTH; i++)
            if (shadow_used[i] && i != slot && shadow_age[i] < shadow_age[slot])
                shadow_age[i]++;
        shadow_age[slot] = 0;
    endfunction

    // applies one request to the shadow; returns 1 when it yields a response word
    function automatic bit cache_access(input lkv_pkg::t_req r, output lkv_pkg::t_rsp rsp);
        int          slot;
        int          oldest;
        int unsigned cap;
        slot   = -1;
        oldest = -1;
        rsp    = '0;
        cap    = (shadow_cap == 0) ? 1 :
                 ((shadow_cap > lkv_pkg::DEPTH) ? lkv_pkg::DEPTH : shadow_cap);
        for (int i = 0; i < lkv_pkg::DEPTH; i++)
            if (slot < 0 && shadow_used[i] && shadow_key[i] == r.key)
                slot = i;
        if (r.op == lkv_pkg::OP_GET) begin
            if (slot >= 0) begin
                rsp.hit        = 1'b1;
                rsp.read_value = shadow_val[slot];
                make_recent(slot);
            end
            return 1'b1;
        end
        if (slot >= 0) begin
            shadow_val[slot] = r.value;
            make_recent(slot);
            return 1'b0;
        end
        if (shadow_fill < cap)
            for (int i = 0; i < lkv_pkg::DEPTH; i++)
                if (slot < 0 && !shadow_used[i])
                    slot = i;
        if (slot < 0) begin
            for (int i = 0; i < lkv_pkg::DEPTH; i++)
                if (shadow_used[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
                    oldest = i;
            slot = (oldest < 0) ? 0 : oldest;
            shadow_used[slot] = 1'b0;
        end else begin
            shadow_fill++;
        end
        for (int i = 0; i < lkv_pkg::DEPTH; i++)
            if (shadow_used[i])
                shadow_age[i]++;
        shadow_key[slot]  = r.key;
        shadow_val[slot]  = r.value;
        shadow_used[slot] = 1'b1;
        shadow_age[slot]  = 0;
        return 1'b0;
    endfunction

    function automatic t_row req_row(lkv_pkg::t_op op, logic [31:0] k, logic [31:0] v,
                                     bit typed = 1'b0, logic hit = 1'b0,
                                     logic [31:0] rv = '0);
        t_row r;
        r.is_cfg          = 1'b0;
        r.cfg_val         = '0;
        r.req.op          = op;
        r.req.key         = k;
        r.req.value       = v;
        r.typed           = typed;
        r.want.hit        = hit;
        r.want.read_value = rv;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [lkv_pkg::CFG_W-1:0] v);
        t_row r;
        r         = req_row(lkv_pkg::OP_GET, '0, '0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // sender: random gaps, valid held high across back-to-back words
    task automatic send_word(lkv_pkg::t_req r, bit typed, lkv_pkg::t_rsp want);
        while (!calm && $urandom_range(99) < 12) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_data    <= r;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    // capacity write, only once the cache has drained
    task automatic write_capacity(logic [lkv_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(99) < 12);

    // model update on accepted words, response check
    always @(posedge i_clk) begin : monitor
        lkv_pkg::t_rsp guess;
        lkv_pkg::t_rsp oldest_exp;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_cap = i_cfg_data;
                n_cfg++;
            end
            if (i_valid && !o_stall) begin
                if (cache_access(i_data, guess)) begin
                    pending_reads.push_back(cur_typed ? cur_want : guess);
                    n_gets++;
                end else begin
                    n_puts++;
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_reads.size() == 0) begin
                    $display("%0t: response word with none pending: hit %0b value %0h",
                             $time, o_data.hit, o_data.read_value);
                    n_errors++;
                end else begin
                    oldest_exp = pending_reads.pop_front();
                    if (oldest_exp.hit) n_hits++;
                    if (o_data.hit !== oldest_exp.hit) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, oldest_exp.hit, o_data.hit);
                        n_errors++;
                    end
                    if (o_data.read_value !== oldest_exp.read_value) begin
                        $display("%0t: read_value expected %0h actual %0h",
                                 $time, oldest_exp.read_value, o_data.read_value);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row             plan [$];
        lkv_pkg::t_req    r;
        logic [31:0]      key_pool [32];
        int               pool_n;
        int               eff;
        logic [31:0]      corner [4];
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000,
                               1'b1, 1'b0, 32'h0));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h8000_0000, 32'h7FFF_FFFF,
                               1'b1, 1'b0, 32'h0));
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                               1'b1, 1'b1, 32'h8000_0000));
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000,
                               1'b1, 1'b1, 32'h7FFF_FFFF));
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF)); // update of a present key
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                               1'b1, 1'b1, 32'hFFFF_FFFF));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               1'b1, 1'b0, 32'h0));
        plan.push_back(cfg_row(5'd0));                                   // zero acts as one
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'd1, 32'd11));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000,
                               1'b1, 1'b0, 32'h0));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                               1'b1, 1'b1, 32'hFFFF_FFFF));
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'd2, 32'd22));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'd1, 32'h0000_0000,
                               1'b1, 1'b0, 32'h0));
        plan.push_back(cfg_row(5'd31));                                  // saturates to depth
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'd3, 32'd33));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'd2, 32'h0000_0000));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'd3, 32'h0000_0000));
        plan.push_back(cfg_row(5'd2));                                   // below current fill
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'd4, 32'd44));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        plan.push_back(req_row(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000));
        plan.push_back(req_row(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(5'd16));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_capacity(plan[i].cfg_val);
            else
                send_word(plan[i].req, plan[i].typed, plan[i].want);
        end

        phase_cap[N_PHASES-1] = $urandom_range(3, 15);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(lkv_pkg::CFG_W'(phase_cap[ph]));
            calm = (ph == 2);
            eff    = (phase_cap[ph] == 0) ? 1 :
                     ((phase_cap[ph] > lkv_pkg::DEPTH) ? lkv_pkg::DEPTH : phase_cap[ph]);
            pool_n = eff + $urandom_range(1, 6);
            for (int k = 0; k < pool_n; k++)
                key_pool[k] = ($urandom_range(7) == 0) ? corner[$urandom_range(3)] : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r.op    = lkv_pkg::t_op'($urandom_range(1));
                r.key   = ($urandom_range(4) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
                r.value = ($urandom_range(15) == 0) ? corner[$urandom_range(3)] : $urandom;
                send_word(r, 1'b0, '0);
            end
            calm = 1'b0;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run: %0d gets (%0d hits), %0d puts, %0d capacity writes",
                 n_gets, n_hits, n_puts, n_cfg);
        $display("run: capacities 0, 1, 2, 4, 16, 17, 31 and %0d, with both sides stalling",
                 phase_cap[N_PHASES-1]);
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
